// ===== hdl/interval_containment_counter_top_assert.svh =====
// Assertion macros for the interval containment counter port checks.
// Used by icc_port_chk only; no other dependencies.
`ifndef INTERVAL_CONTAINMENT_COUNTER_TOP_ASSERT_SVH
`define INTERVAL_CONTAINMENT_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ICC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("icc port check failed");

// Next-cycle implication, disabled in reset.
`define ICC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("icc port check failed");

// Check of the cycle after reset is seen.
`define ICC_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("icc reset check failed");

`endif

// ===== hdl/icc_pkg.sv =====
// Shared types and constants for the interval containment counter.
// No dependencies.
`default_nettype none
package icc_pkg;

    localparam int POS_W     = 6;
    localparam int OUT_W     = 18;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_RUN,
        ST_Q_DRAIN,
        ST_Q_DONE
    } icc_state_t;

    typedef struct packed {
        logic clr;
        logic add;
        logic load;
    } icc_acc_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/icc_mem.sv =====
// Count table: simple dual-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module icc_mem #(
    parameter int AW = 12,
    parameter int DW = 18
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/icc_ctrl.sv =====
// Sequencer: clearing pass, add read-modify-write, query address sweep.
// Depends on icc_pkg.
`default_nettype none
module icc_ctrl #(
    parameter int NUM_POSITIONS = 64,
    parameter int COUNT_BITS    = 18,
    parameter int AW            = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic                         s_tuser,
    input  wire logic [icc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              mem_we,
    output logic      [AW-1:0]                mem_waddr,
    output logic      [COUNT_BITS-1:0]        mem_wdata,
    output logic      [AW-1:0]                mem_raddr,
    input  wire logic [COUNT_BITS-1:0]        mem_rdata,
    output icc_pkg::icc_acc_ctl_t             acc_ctl,
    input  wire logic                         out_free
);

    localparam int PW = AW / 2;
    localparam int CW = (PW > icc_pkg::POS_W) ? PW : icc_pkg::POS_W;
    localparam logic [CW-1:0]         LAST_POS  = CW'(NUM_POSITIONS - 1);
    localparam logic [COUNT_BITS-1:0] ENTRY_MAX = '1;

    icc_pkg::icc_state_t state_reg, state_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] e_reg, e_next;
    logic [CW-1:0] top_reg, top_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          pend_reg, pend_next;

    logic [CW-1:0] lo, hi, hi_clip;
    logic [AW-1:0] addr_cur;

    assign lo       = CW'(s_tdata[icc_pkg::POS_W-1:0]);
    assign hi       = CW'(s_tdata[2*icc_pkg::POS_W-1:icc_pkg::POS_W]);
    assign hi_clip  = (hi > LAST_POS) ? LAST_POS : hi;
    assign addr_cur = {s_reg[PW-1:0], e_reg[PW-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= icc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
        s_reg   <= s_next;
        e_reg   <= e_next;
        top_reg <= top_next;
    end

    always_comb begin
        state_next  = state_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        top_next    = top_reg;
        clr_next    = clr_reg;
        pend_next   = 1'b0;
        s_tready    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_cur;
        mem_wdata   = '0;
        mem_raddr   = addr_cur;
        acc_ctl     = '0;
        acc_ctl.add = pend_reg;
        case (state_reg)
            icc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = icc_pkg::ST_IDLE;
                end
            end
            icc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    s_next   = lo;
                    top_next = hi_clip;
                    if (s_tuser == icc_pkg::ACT_ADD) begin
                        e_next = hi;
                        if (lo <= hi && hi <= LAST_POS) begin
                            state_next = icc_pkg::ST_ADD_RD;
                        end
                    end else begin
                        e_next      = lo;
                        acc_ctl.clr = 1'b1;
                        if (lo <= hi_clip) begin
                            state_next = icc_pkg::ST_Q_RUN;
                        end else begin
                            state_next = icc_pkg::ST_Q_DONE;
                        end
                    end
                end
            end
            icc_pkg::ST_ADD_RD: begin
                state_next = icc_pkg::ST_ADD_WR;
            end
            icc_pkg::ST_ADD_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = (mem_rdata == ENTRY_MAX) ? mem_rdata : mem_rdata + 1'b1;
                state_next = icc_pkg::ST_IDLE;
            end
            icc_pkg::ST_Q_RUN: begin
                pend_next = 1'b1;
                if (e_reg == top_reg) begin
                    if (s_reg == top_reg) begin
                        state_next = icc_pkg::ST_Q_DRAIN;
                    end else begin
                        s_next = s_reg + 1'b1;
                        e_next = s_reg + 1'b1;
                    end
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            icc_pkg::ST_Q_DRAIN: begin
                state_next = icc_pkg::ST_Q_DONE;
            end
            icc_pkg::ST_Q_DONE: begin
                if (out_free) begin
                    acc_ctl.load = 1'b1;
                    state_next   = icc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = icc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/icc_accum.sv =====
// Saturating query accumulator and result output register.
// Depends on icc_pkg.
`default_nettype none
module icc_accum #(
    parameter int COUNT_BITS = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire icc_pkg::icc_acc_ctl_t         acc_ctl,
    input  wire logic [COUNT_BITS-1:0]         rdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [icc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                               out_free
);

    localparam int OW = icc_pkg::OUT_W;
    localparam int SW = ((COUNT_BITS > OW) ? COUNT_BITS : OW) + 1;
    localparam logic [OW-1:0] LIMIT =
        (COUNT_BITS < OW) ? OW'((64'd1 << COUNT_BITS) - 64'd1) : '1;

    logic [OW-1:0] acc_reg, acc_next;
    logic          m_valid_reg, m_valid_next;
    logic [OW-1:0] m_data_reg, m_data_next;
    logic [SW-1:0] sum;

    assign sum = SW'(acc_reg) + SW'(rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (acc_ctl.clr) begin
            acc_next = '0;
        end else if (acc_ctl.add) begin
            acc_next = (sum > SW'(LIMIT)) ? LIMIT : sum[OW-1:0];
        end
        if (acc_ctl.load) begin
            m_valid_next = 1'b1;
            m_data_next  = acc_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(icc_pkg::M_TDATA_W - OW){1'b0}}, m_data_reg};

endmodule
`default_nettype wire

// ===== hdl/interval_containment_counter_top.sv =====
// Interval containment counter, top level.
// Depends on icc_pkg, icc_mem, icc_ctrl, icc_accum.
//
// Counts stored intervals per (start, end) pair in one synchronous RAM of
// 2^(2*clog2(NUM_POSITIONS)) entries. After reset a clearing pass writes one
// entry per cycle with s_tready low. Requests are handled one at a time: an
// add is accepted, read and written back; an ignored add is only accepted.
// A query sweeps (n*(n+1))/2 table entries, with n = min(right,
// NUM_POSITIONS-1) - left + 1, one entry per cycle through the single RAM
// read port. A query with an empty range sweeps no entries. The result
// waits in an output register; a query finishes only once that register
// is free.
`default_nettype none
module interval_containment_counter_top #(
    parameter int NUM_POSITIONS = 64,
    parameter int COUNT_BITS    = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_tuser,  // action
    input  wire logic [icc_pkg::S_TDATA_W-1:0] s_tdata,  // left[5:0], right[11:6]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [icc_pkg::M_TDATA_W-1:0] m_tdata   // match_count[17:0]
);

    localparam int PW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int AW = 2 * PW;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;
    icc_pkg::icc_acc_ctl_t acc_ctl;
    logic                  out_free;

    icc_mem #(
        .AW (AW),
        .DW (COUNT_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    icc_ctrl #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .COUNT_BITS    (COUNT_BITS),
        .AW            (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .acc_ctl   (acc_ctl),
        .out_free  (out_free)
    );

    icc_accum #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc_ctl  (acc_ctl),
        .rdata    (mem_rdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

endmodule
`default_nettype wire

// ===== hdl/icc_port_chk.sv =====
// Port-level checks for interval_containment_counter_top, attached by bind.
// Depends on icc_pkg and interval_containment_counter_top_assert.svh.
`default_nettype none
`include "interval_containment_counter_top_assert.svh"
module icc_port_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [icc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic query_accept;

    assign query_accept = s_tvalid && s_tready && (s_tuser == icc_pkg::ACT_QUERY);

    `ICC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ICC_ASSERT_NEXT(a_query_busy, aclk, aresetn, query_accept, !s_tready)
    `ICC_ASSERT_NOW(a_result_when_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))
    `ICC_ASSERT_RST(a_reset_state, aclk, aresetn, !m_tvalid && !s_tready)

endmodule

bind interval_containment_counter_top icc_port_chk u_icc_port_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
